// ===== sv/qrpm_pkg.sv =====
`timescale 1ns / 1ps
package qrpm_pkg;

  localparam int NUM_AXES  = 3;
  localparam int NUM_MOTOR = 4;
  localparam int STICK_W   = 11;
  localparam int GYRO_W    = 16;
  localparam int GAIN_W    = 16;
  localparam int GAINS_W   = 3 * GAIN_W;
  localparam int DEC_W     = 16;  // centred stick, q8.8, -25600..25600
  localparam int THR_W     = 15;  // throttle, q8.8, 0..25600
  localparam int MIX_W     = 18;
  localparam int ERR_W     = 25;
  localparam int MAG_W     = 24;
  localparam int QUO_W     = 18;
  localparam int SUM_W     = 32;
  localparam int DERIV_W   = 33;
  localparam int ACC_W     = 51;
  localparam int TERM_W    = 32;
  localparam int DUTY_W    = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROLL_GAINS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_GAINS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_GAINS   = 2'd2;

  // kp, ki, kd in q4.12, kp highest
  localparam logic [GAINS_W-1:0] ROLL_GAINS_RST  = 48'h0800_019A_0029;
  localparam logic [GAINS_W-1:0] PITCH_GAINS_RST = 48'h0800_019A_0029;
  localparam logic [GAINS_W-1:0] YAW_GAINS_RST   = 48'h0CCD_019A_0052;

  // ceil(2^32 / 100), exact floor division for values below 2^24
  localparam logic [25:0] DIV100_MUL = 26'd42949673;
  // ceil(2^20 / 100), exact for values up to 25500
  localparam logic [13:0] DUTY_DIV_MUL = 14'd10486;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } pipe_ld_t;

  typedef logic [DUTY_W-1:0] duty_t;

  // floor(m / 4094) for m below 2^17: shift estimate plus one correction
  function automatic logic [4:0] div4094_small(input logic [16:0] m);
    logic [4:0]  q0;
    logic [16:0] r;
    begin
      q0 = m[16:12];
      r  = m - (17'(q0) * 17'd4094);
      if (r >= 17'd4094) begin
        q0 = q0 + 5'd1;
      end
      return q0;
    end
  endfunction

  // round(s * 51200 / 2047) - 25600 = 25s + round(25s / 2047) - 25600
  function automatic logic signed [DEC_W-1:0] decode_centred(input logic [STICK_W-1:0] s);
    logic [15:0]        a;
    logic [16:0]        m;
    logic [16:0]        v;
    logic signed [16:0] c;
    begin
      a = 16'(s) * 16'd25;
      m = {a, 1'b0} + 17'd2047;
      v = 17'(a) + 17'(div4094_small(m));
      c = $signed(v) - 17'sd25600;
      return c[DEC_W-1:0];
    end
  endfunction

  // round(s * 25600 / 2047) = a/2 (floor) + floor((2047*lsb + a + 2047) / 4094), a = 25s
  function automatic logic [THR_W-1:0] decode_throttle(input logic [STICK_W-1:0] s);
    logic [15:0] a;
    logic [16:0] m;
    begin
      a = 16'(s) * 16'd25;
      m = 17'(a) + 17'd2047 + (a[0] ? 17'd2047 : 17'd0);
      return THR_W'(a[15:1]) + THR_W'(div4094_small(m));
    end
  endfunction

  // clamp to 0..25600, then floor(m * 255 / 25600)
  function automatic duty_t duty_of(input logic signed [MIX_W-1:0] m);
    logic [14:0] c;
    logic [22:0] x;
    logic [14:0] y;
    logic [28:0] p;
    begin
      if (m[MIX_W-1]) begin
        c = 15'd0;
      end else if (m > 18'sd25600) begin
        c = 15'd25600;
      end else begin
        c = m[14:0];
      end
      x = 23'(c) * 23'd255;
      y = x[22:8];
      p = 29'(y) * 29'(DUTY_DIV_MUL);
      return p[27:20];
    end
  endfunction

endpackage

// ===== sv/qrpm_stick_decode.sv =====
`timescale 1ns / 1ps
module qrpm_stick_decode
  import qrpm_pkg::*;
(
  input  logic [STICK_W-1:0]      roll_stick,
  input  logic [STICK_W-1:0]      pitch_stick,
  input  logic [STICK_W-1:0]      yaw_stick,
  input  logic [STICK_W-1:0]      throttle_stick,
  input  logic                    link_up,
  output logic signed [DEC_W-1:0] roll_dec,
  output logic signed [DEC_W-1:0] pitch_dec,
  output logic signed [DEC_W-1:0] yaw_dec,
  output logic [THR_W-1:0]        thr_dec
);

  // sticks read as zero while the link is down
  logic [STICK_W-1:0] rs, ps, ys, ts;

  always_comb begin
    rs = link_up ? roll_stick     : '0;
    ps = link_up ? pitch_stick    : '0;
    ys = link_up ? yaw_stick      : '0;
    ts = link_up ? throttle_stick : '0;
    roll_dec  = decode_centred(rs);
    pitch_dec = decode_centred(ps);
    yaw_dec   = decode_centred(ys);
    thr_dec   = decode_throttle(ts);
  end

endmodule

// ===== sv/qrpm_mixer.sv =====
`timescale 1ns / 1ps
module qrpm_mixer
  import qrpm_pkg::*;
(
  input  logic signed [DEC_W-1:0] roll_dec,
  input  logic signed [DEC_W-1:0] pitch_dec,
  input  logic signed [DEC_W-1:0] yaw_dec,
  input  logic [THR_W-1:0]        thr_dec,
  input  logic                    link_up,
  output duty_t                   duty [NUM_MOTOR]
);

  logic signed [MIX_W-1:0] r, p, y, t;
  logic signed [MIX_W-1:0] m [NUM_MOTOR];

  always_comb begin
    r = MIX_W'(roll_dec);
    p = MIX_W'(pitch_dec);
    y = MIX_W'(yaw_dec);
    t = $signed({{(MIX_W-THR_W){1'b0}}, thr_dec});
    // x layout
    m[0] = t + r - p - y;
    m[1] = t - r - p + y;
    m[2] = t + r + p + y;
    m[3] = t - r + p - y;
    for (int i = 0; i < NUM_MOTOR; i++) begin
      duty[i] = link_up ? duty_of(m[i]) : '0;
    end
  end

endmodule

// ===== sv/qrpm_pid_lane.sv =====
`timescale 1ns / 1ps
module qrpm_pid_lane
  import qrpm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  pipe_ld_t                 ld,
  input  logic [GAINS_W-1:0]       gains,
  input  logic signed [ERR_W-1:0]  err_in,
  output logic signed [TERM_W-1:0] term
);

  localparam int RQ_W = ACC_W - 12;

  // stage 2: error and rounded error / 100
  logic signed [ERR_W-1:0] err2_r;
  logic signed [QUO_W-1:0] quo2_r;
  logic signed [ERR_W-1:0] err_neg;
  logic [MAG_W-1:0]        mag;
  logic [MAG_W-1:0]        mag_rnd;
  logic [MAG_W+25:0]       qprod;
  logic [QUO_W-1:0]        qmag;
  logic signed [QUO_W-1:0] quo_nxt;

  always_comb begin
    err_neg = -err_in;
    mag     = err_in[ERR_W-1] ? err_neg[MAG_W-1:0] : err_in[MAG_W-1:0];
    mag_rnd = mag + MAG_W'(50);
    qprod   = (MAG_W+26)'(mag_rnd) * (MAG_W+26)'(DIV100_MUL);
    qmag    = {1'b0, qprod[48:32]};
    quo_nxt = err_in[ERR_W-1] ? -$signed(qmag) : $signed(qmag);
  end

  always_ff @(posedge clk) begin
    if (ld.s2) begin
      err2_r <= err_in;
      quo2_r <= quo_nxt;
    end
  end

  // stage 3: integrator and last error, also the lane state
  logic signed [SUM_W-1:0]   error_sum_r, error_sum_nxt;
  logic signed [ERR_W-1:0]   last_error_r;
  logic signed [DERIV_W-1:0] deriv3_r, deriv_nxt;
  logic signed [SUM_W:0]     sum_w;
  logic signed [ERR_W:0]     diff;

  always_comb begin
    sum_w = (SUM_W+1)'(error_sum_r) + (SUM_W+1)'(quo2_r);
    if (sum_w[SUM_W] != sum_w[SUM_W-1]) begin
      error_sum_nxt = sum_w[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      error_sum_nxt = sum_w[SUM_W-1:0];
    end
    diff      = (ERR_W+1)'(err2_r) - (ERR_W+1)'(last_error_r);
    deriv_nxt = DERIV_W'(diff) * 33'sd100;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r  <= '0;
      last_error_r <= '0;
    end else if (ld.s3) begin
      error_sum_r  <= error_sum_nxt;
      last_error_r <= err2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.s3) begin
      deriv3_r <= deriv_nxt;
    end
  end

  // stage 4: gain products
  logic signed [GAIN_W+ERR_W:0]   pk;
  logic signed [GAIN_W+SUM_W:0]   pi;
  logic signed [GAIN_W+DERIV_W:0] pd;
  logic signed [ACC_W-1:0]        pk_r, pi_r, pd_r;

  always_comb begin
    pk = $signed({1'b0, gains[3*GAIN_W-1:2*GAIN_W]}) * last_error_r;
    pi = $signed({1'b0, gains[2*GAIN_W-1:GAIN_W]}) * error_sum_r;
    pd = $signed({1'b0, gains[GAIN_W-1:0]}) * deriv3_r;
  end

  always_ff @(posedge clk) begin
    if (ld.s4) begin
      pk_r <= ACC_W'(pk);
      pi_r <= ACC_W'(pi);
      pd_r <= ACC_W'(pd);
    end
  end

  // sum, round half away from zero by 4096, saturate
  logic signed [ACC_W-1:0] acc, acc_inv;
  logic                    acc_neg;
  logic [ACC_W-1:0]        acc_mag, acc_rnd;
  logic [RQ_W-1:0]         rq;
  logic [TERM_W-1:0]       rq_low;

  always_comb begin
    acc     = pk_r + pi_r + pd_r;
    acc_inv = -acc;
    acc_neg = acc[ACC_W-1];
    acc_mag = acc_neg ? acc_inv : acc;
    acc_rnd = acc_mag + ACC_W'(2048);
    rq      = acc_rnd[ACC_W-1:12];
    rq_low  = rq[TERM_W-1:0];
    if (acc_neg) begin
      term = (rq > RQ_W'(32'h8000_0000)) ? $signed(32'h8000_0000) : -$signed(rq_low);
    end else begin
      term = (rq > RQ_W'(32'h7FFF_FFFF)) ? $signed(32'h7FFF_FFFF) : $signed(rq_low);
    end
  end

endmodule

// ===== sv/quad_rate_pid_and_motor_mixer.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    four sticks, three gyro rates, link_up
// out       output     out_valid / out_ready  four motor duties, three pid terms
// cfg       input      cfg_we (no wait)       cfg_index, cfg_data (48-bit gain word)
//
// one item per cycle sustained while out_ready is high
// the depth is set by the rate pid lanes: decode, divide by 100, integrate, gains, round
// synchronous active-low reset clears the pipeline valids and the pid state, reloads default gains
// a stall at out_ready holds only the full stages; empty stages behind it keep filling
module quad_rate_pid_and_motor_mixer
  import qrpm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // input items
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [STICK_W-1:0]       in_roll_stick,
  input  logic [STICK_W-1:0]       in_pitch_stick,
  input  logic [STICK_W-1:0]       in_yaw_stick,
  input  logic [STICK_W-1:0]       in_throttle_stick,
  input  logic signed [GYRO_W-1:0] in_gyro_roll,
  input  logic signed [GYRO_W-1:0] in_gyro_pitch,
  input  logic signed [GYRO_W-1:0] in_gyro_yaw,
  input  logic                     in_link_up,
  // result items
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [DUTY_W-1:0]        out_duty_front_a,
  output logic [DUTY_W-1:0]        out_duty_front_b,
  output logic [DUTY_W-1:0]        out_duty_rear_a,
  output logic [DUTY_W-1:0]        out_duty_rear_b,
  output logic signed [TERM_W-1:0] out_roll_term,
  output logic signed [TERM_W-1:0] out_pitch_term,
  output logic signed [TERM_W-1:0] out_yaw_term,
  // gain registers
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [GAINS_W-1:0]       cfg_data
);

  // ---------------------------------------------------------------------------
  // pipeline control: each stage loads when it is empty or drains this cycle
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt, out_valid_nxt;
  logic ld1, ld2, ld3, ld4, ld5;
  pipe_ld_t lane_ld;

  always_comb begin
    ld5 = v4_r && (!out_valid_r || out_ready);
    ld4 = v3_r && (!v4_r || ld5);
    ld3 = v2_r && (!v3_r || ld4);
    ld2 = v1_r && (!v2_r || ld3);
    in_ready = !v1_r || ld2;
    ld1 = in_valid && in_ready;

    v1_nxt        = ld1 || (v1_r && !ld2);
    v2_nxt        = ld2 || (v2_r && !ld3);
    v3_nxt        = ld3 || (v3_r && !ld4);
    v4_nxt        = ld4 || (v4_r && !ld5);
    out_valid_nxt = ld5 || (out_valid_r && !out_ready);

    lane_ld.s2 = ld2;
    lane_ld.s3 = ld3;
    lane_ld.s4 = ld4;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      v4_r        <= v4_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------------
  // gain registers, one 48-bit word per axis; unknown index is dropped
  // ---------------------------------------------------------------------------
  logic [GAINS_W-1:0] gains_r [NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r[0] <= ROLL_GAINS_RST;
      gains_r[1] <= PITCH_GAINS_RST;
      gains_r[2] <= YAW_GAINS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROLL_GAINS:  gains_r[0] <= cfg_data;
        CFG_PITCH_GAINS: gains_r[1] <= cfg_data;
        CFG_YAW_GAINS:   gains_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: stick decode to percent q8.8 and rate error per axis
  // ---------------------------------------------------------------------------
  logic signed [DEC_W-1:0]  roll_dec, pitch_dec, yaw_dec;
  logic [THR_W-1:0]         thr_dec;
  logic signed [DEC_W-1:0]  dec_vec [NUM_AXES];
  logic signed [GYRO_W-1:0] gyro_vec [NUM_AXES];
  logic signed [ERR_W-1:0]  err_nxt [NUM_AXES];

  qrpm_stick_decode u_decode (
    .roll_stick     (in_roll_stick),
    .pitch_stick    (in_pitch_stick),
    .yaw_stick      (in_yaw_stick),
    .throttle_stick (in_throttle_stick),
    .link_up        (in_link_up),
    .roll_dec       (roll_dec),
    .pitch_dec      (pitch_dec),
    .yaw_dec        (yaw_dec),
    .thr_dec        (thr_dec)
  );

  always_comb begin
    dec_vec[0]  = roll_dec;
    dec_vec[1]  = pitch_dec;
    dec_vec[2]  = yaw_dec;
    gyro_vec[0] = in_gyro_roll;
    gyro_vec[1] = in_gyro_pitch;
    gyro_vec[2] = in_gyro_yaw;
    // error = decoded stick - gyro * 256, always fits 25 bits
    for (int i = 0; i < NUM_AXES; i++) begin
      err_nxt[i] = {{(ERR_W-DEC_W){dec_vec[i][DEC_W-1]}}, dec_vec[i]}
                 - {gyro_vec[i][GYRO_W-1], gyro_vec[i], 8'd0};
    end
  end

  logic signed [DEC_W-1:0] roll1_r, pitch1_r, yaw1_r;
  logic [THR_W-1:0]        thr1_r;
  logic                    link1_r;
  logic signed [ERR_W-1:0] err1_r [NUM_AXES];

  always_ff @(posedge clk) begin
    if (ld1) begin
      roll1_r  <= roll_dec;
      pitch1_r <= pitch_dec;
      yaw1_r   <= yaw_dec;
      thr1_r   <= thr_dec;
      link1_r  <= in_link_up;
      for (int i = 0; i < NUM_AXES; i++) begin
        err1_r[i] <= err_nxt[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // motor mix from sticks alone, computed into stage 2 and carried along
  // ---------------------------------------------------------------------------
  duty_t duty_mix [NUM_MOTOR];
  duty_t duty2_r [NUM_MOTOR];
  duty_t duty3_r [NUM_MOTOR];
  duty_t duty4_r [NUM_MOTOR];
  logic  link2_r, link3_r, link4_r;

  qrpm_mixer u_mixer (
    .roll_dec  (roll1_r),
    .pitch_dec (pitch1_r),
    .yaw_dec   (yaw1_r),
    .thr_dec   (thr1_r),
    .link_up   (link1_r),
    .duty      (duty_mix)
  );

  always_ff @(posedge clk) begin
    if (ld2) begin
      duty2_r <= duty_mix;
      link2_r <= link1_r;
    end
    if (ld3) begin
      duty3_r <= duty2_r;
      link3_r <= link2_r;
    end
    if (ld4) begin
      duty4_r <= duty3_r;
      link4_r <= link3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // rate pid lanes, one per axis, stages 2 to 4
  // ---------------------------------------------------------------------------
  logic signed [TERM_W-1:0] lane_term [NUM_AXES];

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    qrpm_pid_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ld     (lane_ld),
      .gains  (gains_r[g]),
      .err_in (err1_r[g]),
      .term   (lane_term[g])
    );
  end

  // ---------------------------------------------------------------------------
  // output register: merges lane terms with the carried duties
  // ---------------------------------------------------------------------------
  duty_t                   out_duty_r [NUM_MOTOR];
  logic signed [TERM_W-1:0] out_term_r [NUM_AXES];
  logic                    out_link_r;

  always_ff @(posedge clk) begin
    if (ld5) begin
      out_duty_r <= duty4_r;
      out_term_r <= lane_term;
      out_link_r <= link4_r;
    end
  end

  assign out_duty_front_a = out_duty_r[0];
  assign out_duty_front_b = out_duty_r[1];
  assign out_duty_rear_a  = out_duty_r[2];
  assign out_duty_rear_b  = out_duty_r[3];
  assign out_roll_term    = out_term_r[0];
  assign out_pitch_term   = out_term_r[1];
  assign out_yaw_term     = out_term_r[2];

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // pipeline comes out of reset empty and open
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("pipeline not empty after reset");

  // a held result with every stage full must block the input
  a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && v1_r && v2_r && v3_r && v4_r) |-> !in_ready)
    else $error("item accepted into a full stalled pipeline");

  // motors stay off for an item taken with the link down
  a_link_down_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_link_r) |->
      (out_duty_front_a == '0 && out_duty_front_b == '0 &&
       out_duty_rear_a == '0 && out_duty_rear_b == '0))
    else $error("nonzero duty with link down");

endmodule
